### hdl/longest_unique_letter_run_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest unique letter run block
// Shared property forms; each module that uses them has ports clock and reset.
// ----------------------------------------------------------------------------
`ifndef LONGEST_UNIQUE_LETTER_RUN_ASSERT_SVH
`define LONGEST_UNIQUE_LETTER_RUN_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LULR_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LULR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

### hdl/lulr_pkg.sv
// ----------------------------------------------------------------------------
// lulr_pkg
// Types, constants and the letter classifier shared by the run finder.
// ----------------------------------------------------------------------------
package lulr_pkg;

   localparam int MAX_TEXT_LEN = 4096;
   localparam int NUM_LETTERS  = 26;
   localparam int RING_DEPTH   = 32;
   // The queue depth must be a power of two so the pointers wrap by themselves.
   localparam int QUEUE_DEPTH  = 2;

   localparam int POS_W       = $clog2(MAX_TEXT_LEN + 1);
   localparam int LETTER_W    = $clog2(NUM_LETTERS);
   localparam int LEN_W       = $clog2(NUM_LETTERS + 1);
   localparam int RING_W      = $clog2(RING_DEPTH);
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef logic [7:0]                char_type;
   typedef logic [POS_W-1:0]          pos_type;
   typedef logic [LEN_W-1:0]          len_type;
   typedef logic [RING_W-1:0]         ring_idx_type;
   typedef logic [LETTER_W-1:0]       letter_type;
   typedef char_type [RING_DEPTH-1:0] ring_type;

   localparam char_type CHAR_LC_A = 8'h61;
   localparam char_type CHAR_LC_Z = 8'h7a;
   localparam char_type CHAR_UC_A = 8'h41;
   localparam char_type CHAR_UC_Z = 8'h5a;
   localparam char_type CHAR_NONE = 8'h00;

   typedef struct packed {
      logic       is_letter;
      letter_type idx;
   } letter_info_type;

   // One finished text: a copy of the byte ring taken when the best run was
   // found, where that run starts in the ring, its length and the drop flag.
   typedef struct packed {
      ring_type     snap;
      ring_idx_type start;
      len_type      len;
      logic         trunc;
   } job_type;

   function automatic letter_info_type classify(input char_type ch);
      letter_info_type info;
      info.is_letter = 1'b0;
      info.idx       = '0;
      if (ch >= CHAR_LC_A && ch <= CHAR_LC_Z) begin
         info.is_letter = 1'b1;
         info.idx       = LETTER_W'(ch - CHAR_LC_A);
      end else if (ch >= CHAR_UC_A && ch <= CHAR_UC_Z) begin
         info.is_letter = 1'b1;
         info.idx       = LETTER_W'(ch - CHAR_UC_A);
      end
      return info;
   endfunction

endpackage

### hdl/lulr_front.sv
// ----------------------------------------------------------------------------
// lulr_front
// Classifies each input byte and tracks the current and best letter runs.
// ----------------------------------------------------------------------------
module lulr_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  lulr_pkg::char_type req_char_in,
   input  logic              req_end_of_text,
   output logic              push,
   output lulr_pkg::job_type push_job,
   input  logic              q_full
);

   // Classify stage
   logic                      s1_valid_ff;
   lulr_pkg::char_type        s1_char_ff;
   logic                      s1_eot_ff;
   lulr_pkg::letter_info_type s1_info_ff;
   logic                      s1_adv;

   // Scan state
   lulr_pkg::pos_type      position_ff;
   lulr_pkg::pos_type      start_ff;
   lulr_pkg::len_type      best_len_ff;
   lulr_pkg::ring_idx_type best_start_ff;
   lulr_pkg::ring_type     best_snap_ff;
   lulr_pkg::ring_type     ring_ff;
   logic                   overflow_ff;
   logic [lulr_pkg::NUM_LETTERS-1:0] seen_ff;
   lulr_pkg::pos_type      last_pos_ff [lulr_pkg::NUM_LETTERS];

   logic                   take;
   lulr_pkg::ring_type     ring_in;
   lulr_pkg::pos_type      last_pos;
   logic                   hit;
   lulr_pkg::pos_type      start_in;
   lulr_pkg::pos_type      cur_len_wide;
   lulr_pkg::len_type      cur_len;
   logic                   better;

   // An end-of-text word waits here while the queue has no room.
   assign s1_adv    = s1_valid_ff && !(s1_eot_ff && q_full);
   assign req_stall = s1_valid_ff && !s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         s1_char_ff <= req_char_in;
         s1_eot_ff  <= req_end_of_text;
         s1_info_ff <= lulr_pkg::classify(req_char_in);
      end
   end

   always_comb begin
      take = s1_adv && (position_ff < lulr_pkg::POS_W'(lulr_pkg::MAX_TEXT_LEN));
      ring_in = ring_ff;
      ring_in[position_ff[lulr_pkg::RING_W-1:0]] = s1_char_ff;
      last_pos = last_pos_ff[s1_info_ff.idx];
      hit = s1_info_ff.is_letter && seen_ff[s1_info_ff.idx] && (last_pos >= start_ff);
      if (!s1_info_ff.is_letter) begin
         start_in = position_ff + 1'b1;
      end else if (hit) begin
         start_in = last_pos + 1'b1;
      end else begin
         start_in = start_ff;
      end
      // A run without repeats holds at most 26 letters, so the low bits suffice.
      cur_len_wide = position_ff - start_in + 1'b1;
      cur_len      = cur_len_wide[lulr_pkg::LEN_W-1:0];
      better       = take && s1_info_ff.is_letter && (cur_len > best_len_ff);
   end

   assign push = s1_adv && s1_eot_ff;

   always_comb begin
      push_job.snap  = better ? ring_in : best_snap_ff;
      push_job.start = better ? start_in[lulr_pkg::RING_W-1:0] : best_start_ff;
      push_job.len   = better ? cur_len : best_len_ff;
      push_job.trunc = overflow_ff || (s1_adv && !take);
   end

   always_ff @(posedge clock) begin
      if (reset || push) begin
         position_ff <= '0;
         start_ff    <= '0;
         best_len_ff <= '0;
         overflow_ff <= 1'b0;
         seen_ff     <= '0;
      end else if (take) begin
         position_ff <= position_ff + 1'b1;
         start_ff    <= start_in;
         if (better) begin
            best_len_ff <= cur_len;
         end
         if (s1_info_ff.is_letter) begin
            seen_ff[s1_info_ff.idx] <= 1'b1;
         end
      end else if (s1_adv) begin
         overflow_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         ring_ff <= ring_in;
         if (s1_info_ff.is_letter) begin
            last_pos_ff[s1_info_ff.idx] <= position_ff;
         end
         if (better) begin
            best_snap_ff  <= ring_in;
            best_start_ff <= start_in[lulr_pkg::RING_W-1:0];
         end
      end
   end

endmodule

### hdl/lulr_queue.sv
// ----------------------------------------------------------------------------
// lulr_queue
// Short queue of finished texts between the scanner and the emitter.
// ----------------------------------------------------------------------------
`include "longest_unique_letter_run_assert.svh"

module lulr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lulr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output lulr_pkg::job_type head_job
);

   lulr_pkg::job_type                 store_ff [lulr_pkg::QUEUE_DEPTH];
   logic [lulr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_ff;
   logic [lulr_pkg::QUEUE_PTR_W-1:0]  rd_ptr_ff;
   logic [lulr_pkg::QUEUE_CNT_W-1:0]  count_ff;

   assign full       = (count_ff == lulr_pkg::QUEUE_CNT_W'(lulr_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = store_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   `LULR_ASSERT_IMPL(a_no_push_when_full, push, !full)
   `LULR_ASSERT_IMPL(a_no_pop_when_empty, pop, head_valid)
   `LULR_ASSERT_NEXT(a_count_rises_on_push, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

### hdl/lulr_back.sv
// ----------------------------------------------------------------------------
// lulr_back
// Emits the best run of the text at the queue head, one character a word.
// ----------------------------------------------------------------------------
`include "longest_unique_letter_run_assert.svh"

module lulr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  lulr_pkg::job_type  head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lulr_pkg::char_type rsp_out_char,
   output logic               rsp_run_last,
   output logic               rsp_empty_run,
   output logic               rsp_truncated
);

   lulr_pkg::len_type      k_ff;
   logic                   rsp_valid_ff;
   lulr_pkg::char_type     rsp_char_ff;
   logic                   rsp_last_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_trunc_ff;
   logic                   load;
   logic                   is_empty;
   logic                   is_last;
   lulr_pkg::ring_idx_type rd_idx;

   assign load     = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign is_empty = (head_job.len == '0);
   assign is_last  = is_empty || (k_ff == head_job.len - 1'b1);
   assign pop      = load && is_last;
   assign rd_idx   = head_job.start + lulr_pkg::RING_W'(k_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            k_ff         <= is_last ? '0 : k_ff + 1'b1;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff  <= is_empty ? lulr_pkg::CHAR_NONE : head_job.snap[rd_idx];
         rsp_last_ff  <= is_last;
         rsp_empty_ff <= is_empty;
         rsp_trunc_ff <= head_job.trunc;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_run_last  = rsp_last_ff;
   assign rsp_empty_run = rsp_empty_ff;
   assign rsp_truncated = rsp_trunc_ff;

   `LULR_ASSERT_IMPL(a_empty_word_is_last_zero, rsp_valid_ff && rsp_empty_ff, rsp_last_ff && (rsp_char_ff == lulr_pkg::CHAR_NONE))
   `LULR_ASSERT_IMPL(a_count_only_inside_text, k_ff != '0, head_valid)

endmodule

### hdl/longest_unique_letter_run.sv
// ----------------------------------------------------------------------------
// longest_unique_letter_run
// Finds the longest run of distinct letters in a byte stream and emits it.
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle with no bubbles, also across text
// boundaries, unless req_stall is high; a byte reaches the scanner in the cycle
// after it is accepted. When the byte marked end of text has been scanned, the
// best run of that text goes into a two-entry queue and the emitter sends it
// one character per cycle unless rsp_stall is high, giving max(n, 1) words for
// a run of length n (at most 26). Only an end-of-text word that finds both
// queue entries still waiting stalls the input, and waits in the scanner stage.
// Results pass from the scanner stage through the queue to the output register.
module longest_unique_letter_run (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lulr_pkg::char_type req_char_in,
   input  logic               req_end_of_text,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lulr_pkg::char_type rsp_out_char,
   output logic               rsp_run_last,
   output logic               rsp_empty_run,
   output logic               rsp_truncated
);

   logic              push;
   lulr_pkg::job_type push_job;
   logic              q_full;
   logic              pop;
   logic              head_valid;
   lulr_pkg::job_type head_job;

   lulr_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .push            (push),
      .push_job        (push_job),
      .q_full          (q_full)
   );

   lulr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   lulr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_run_last  (rsp_run_last),
      .rsp_empty_run (rsp_empty_run),
      .rsp_truncated (rsp_truncated)
   );

endmodule
